// ===== sv/pei_pkg.sv =====
// Shared types and constants for the particle Euler integrator.
// No dependencies; imported by every module of the block.
package pei_pkg;

    localparam int WORD_BITS = 32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GRAVITY_X = 2'd0,
        REG_GRAVITY_Y = 2'd1,
        REG_GRAVITY_Z = 2'd2,
        REG_TIME_STEP = 2'd3
    } cfg_reg_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]                  axis;
        logic [WORD_BITS-2:0]        mass;
        logic [WORD_BITS-2:0]        moment_of_inertia;
        logic signed [WORD_BITS-1:0] force_req;
        logic signed [WORD_BITS-1:0] torque;
        logic signed [WORD_BITS-1:0] velocity;
        logic signed [WORD_BITS-1:0] angular_velocity;
        logic signed [WORD_BITS-1:0] position;
    } req_t;

    typedef struct packed {
        logic [1:0]                  axis_out;
        logic signed [WORD_BITS-1:0] new_velocity;
        logic signed [WORD_BITS-1:0] new_angular_velocity;
        logic signed [WORD_BITS-1:0] new_position;
        logic                        overflow;
    } rsp_t;

endpackage

// ===== sv/pei_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturating result.
// Computes (num * 2^FRAC_BITS) / den truncated toward zero; depends on pei_pkg.
module pei_div
    import pei_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] num,
    input  logic [WORD_BITS-2:0]        den,
    output logic signed [WORD_BITS-1:0] quo,
    output logic                        ovf
);

    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;
    localparam int D = WORD_BITS - 1;

    logic [D-1:0] rem_reg  [N+1];
    logic [N-1:0] dq_reg   [N+1];
    logic [D-1:0] den_reg  [N+1];
    logic         neg_reg  [N+1];
    logic         zero_reg [N+1];

    logic [W-1:0] mag;
    logic signed [W-1:0] quo_reg, quo_next;
    logic         ovf_reg, ovf_next;
    logic [N-1:0] mag_q;
    logic         pos_fit;
    logic         neg_fit;

    // Most negative input has magnitude 2^(W-1), which still fits unsigned
    assign mag = num[W-1] ? W'(-num) : W'(num);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            dq_reg[0]   <= {mag, {FRAC_BITS{1'b0}}};
            den_reg[0]  <= den;
            neg_reg[0]  <= num[W-1];
            zero_reg[0] <= (den == '0);
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [D:0] trial;
        logic       fit;

        assign trial = {rem_reg[k], dq_reg[k][N-1]};
        assign fit   = (trial >= {1'b0, den_reg[k]});

        // Shift the dividend out at the top, the quotient bit in at the bottom
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= fit ? D'(trial - {1'b0, den_reg[k]}) : trial[D-1:0];
                dq_reg[k+1]   <= {dq_reg[k][N-2:0], fit};
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign mag_q   = dq_reg[N];
    assign pos_fit = (mag_q[N-1:W-1] == '0);
    assign neg_fit = pos_fit || ((mag_q[N-1:W] == '0) && (mag_q[W-2:0] == '0));

    always_comb
    begin
        quo_next = mag_q[W-1:0];
        ovf_next = 1'b0;
        if (zero_reg[N])
        begin
            quo_next = '0;
            ovf_next = 1'b1;
        end
        else if (neg_reg[N])
        begin
            if (neg_fit)
            begin
                quo_next = -$signed(mag_q[W-1:0]);
            end
            else
            begin
                quo_next = {1'b1, {(W-1){1'b0}}};
                ovf_next = 1'b1;
            end
        end
        else if (!pos_fit)
        begin
            quo_next = {1'b0, {(W-1){1'b1}}};
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
            ovf_reg <= ovf_next;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

// ===== sv/pei_adv.sv =====
// Two-stage Euler advance: base + floor(dt * rate / 2^FRAC_BITS), saturated.
// Stage one multiplies, stage two shifts, adds and clamps; depends on pei_pkg.
module pei_adv
    import pei_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [WORD_BITS-2:0]        dt,
    input  logic signed [WORD_BITS-1:0] base,
    input  logic signed [WORD_BITS-1:0] rate,
    output logic signed [WORD_BITS-1:0] result,
    output logic                        ovf
);

    localparam int W = WORD_BITS;
    localparam int P = 2 * WORD_BITS;
    localparam int S = P + 1;

    logic signed [P-1:0] prod_reg;
    logic signed [W-1:0] base_reg;
    logic signed [P-1:0] shifted;
    logic [S-1:0]        sum;
    logic                fit;
    logic signed [W-1:0] result_reg, result_next;
    logic                ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= $signed({1'b0, dt}) * rate;
            base_reg <= base;
        end
    end

    // Arithmetic shift rounds toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;
    assign sum     = {{(S-W){base_reg[W-1]}}, base_reg} + {shifted[P-1], shifted};
    assign fit     = (&sum[S-1:W-1]) || (~|sum[S-1:W-1]);

    assign result_next = fit ? sum[W-1:0] : {sum[S-1], {(W-1){~sum[S-1]}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            ovf_reg    <= ~fit;
        end
    end

    assign result = result_reg;
    assign ovf    = ovf_reg;

endmodule

// ===== sv/particle_euler_integrator.sv =====
// Top level of the particle Euler integrator: config registers, pipeline, output skid.
// Depends on pei_pkg, pei_div and pei_adv.
//
// One request carries one axis of one particle; one response comes back per request,
// in order. The block takes a request every cycle as long as the output side drains.
// The pipeline runs through the divider, which retires one quotient bit per stage, then the
// acceleration stage, two multiply-accumulate advances of two stages each and the output
// register. A one-entry skid buffer behind the output register decouples rsp_ready from
// req_ready. Gravity and time step are to be written through the cfg port while idle;
// the user must keep to this, as the block itself does not enforce it.
module particle_euler_integrator
    import pei_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    localparam int W       = WORD_BITS;
    localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 2;

    typedef struct packed {
        logic [1:0]          axis;
        logic signed [W-1:0] grav;
        logic signed [W-1:0] vel;
        logic signed [W-1:0] omega;
        logic signed [W-1:0] pos;
    } side_t;

    // Configuration registers
    logic signed [W-1:0] gravity_x_reg, gravity_y_reg, gravity_z_reg;
    logic [W-2:0]        time_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_x_reg <= '0;
            gravity_y_reg <= '0;
            gravity_z_reg <= '0;
            time_step_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRAVITY_X: gravity_x_reg <= cfg_data;
                REG_GRAVITY_Y: gravity_y_reg <= cfg_data;
                REG_GRAVITY_Z: gravity_z_reg <= cfg_data;
                REG_TIME_STEP: time_step_reg <= cfg_data[W-2:0];
                default:       ;
            endcase
        end
    end

    // Pipeline advance: the whole pipe holds while the skid entry is occupied
    logic en;
    logic skid_valid_reg;

    assign en        = ~skid_valid_reg;
    assign req_ready = en;

    // Divider front end plus side data
    side_t               side_in;
    side_t               side_reg [DIV_LAT];
    logic [DIV_LAT-1:0]  vld_reg;
    logic signed [W-1:0] quo_f, quo_t;
    logic                ovf_f, ovf_t;

    always_comb
    begin
        side_in.axis  = req_data.axis;
        side_in.vel   = req_data.velocity;
        side_in.omega = req_data.angular_velocity;
        side_in.pos   = req_data.position;
        case (req_data.axis)
            AXIS_X:  side_in.grav = gravity_x_reg;
            AXIS_Y:  side_in.grav = gravity_y_reg;
            AXIS_Z:  side_in.grav = gravity_z_reg;
            default: side_in.grav = '0;
        endcase
    end

    pei_div #(.FRAC_BITS(FRAC_BITS)) u_div_force (
        .clk (clk),
        .en  (en),
        .num (req_data.force_req),
        .den (req_data.mass),
        .quo (quo_f),
        .ovf (ovf_f)
    );

    pei_div #(.FRAC_BITS(FRAC_BITS)) u_div_torque (
        .clk (clk),
        .en  (en),
        .num (req_data.torque),
        .den (req_data.moment_of_inertia),
        .quo (quo_t),
        .ovf (ovf_t)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Acceleration stage: gravity plus force quotient, clamped
    side_t               sd;
    logic [W:0]          acc_sum;
    logic                acc_fit;
    logic signed [W-1:0] acc_next;

    assign sd       = side_reg[DIV_LAT-1];
    assign acc_sum  = {sd.grav[W-1], sd.grav} + {quo_f[W-1], quo_f};
    assign acc_fit  = (acc_sum[W] == acc_sum[W-1]);
    assign acc_next = acc_fit ? acc_sum[W-1:0] : {acc_sum[W], {(W-1){~acc_sum[W]}}};

    logic                a_vld_reg;
    logic [1:0]          a_axis_reg;
    logic signed [W-1:0] a_acc_reg, a_alpha_reg, a_vel_reg, a_omega_reg, a_pos_reg;
    logic                a_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_axis_reg  <= sd.axis;
            a_acc_reg   <= acc_next;
            a_alpha_reg <= quo_t;
            a_vel_reg   <= sd.vel;
            a_omega_reg <= sd.omega;
            a_pos_reg   <= sd.pos;
            a_ovf_reg   <= ovf_f | ovf_t | ~acc_fit;
        end
    end

    // Velocity and angular velocity advance in parallel
    logic signed [W-1:0] nv, nw;
    logic                ovf_v, ovf_w;

    pei_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_vel (
        .clk    (clk),
        .en     (en),
        .dt     (time_step_reg),
        .base   (a_vel_reg),
        .rate   (a_acc_reg),
        .result (nv),
        .ovf    (ovf_v)
    );

    pei_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_omega (
        .clk    (clk),
        .en     (en),
        .dt     (time_step_reg),
        .base   (a_omega_reg),
        .rate   (a_alpha_reg),
        .result (nw),
        .ovf    (ovf_w)
    );

    logic                b1_vld_reg, b2_vld_reg;
    logic [1:0]          b1_axis_reg, b2_axis_reg;
    logic signed [W-1:0] b1_pos_reg, b2_pos_reg;
    logic                b1_ovf_reg, b2_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_axis_reg <= a_axis_reg;
            b1_pos_reg  <= a_pos_reg;
            b1_ovf_reg  <= a_ovf_reg;
            b2_axis_reg <= b1_axis_reg;
            b2_pos_reg  <= b1_pos_reg;
            b2_ovf_reg  <= b1_ovf_reg;
        end
    end

    // Position advance uses the new velocity
    logic signed [W-1:0] np;
    logic                ovf_p;

    pei_adv #(.FRAC_BITS(FRAC_BITS)) u_adv_pos (
        .clk    (clk),
        .en     (en),
        .dt     (time_step_reg),
        .base   (b2_pos_reg),
        .rate   (nv),
        .result (np),
        .ovf    (ovf_p)
    );

    logic                c1_vld_reg, c2_vld_reg;
    logic [1:0]          c1_axis_reg, c2_axis_reg;
    logic signed [W-1:0] c1_nv_reg, c2_nv_reg, c1_nw_reg, c2_nw_reg;
    logic                c1_ovf_reg, c2_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_axis_reg <= b2_axis_reg;
            c1_nv_reg   <= nv;
            c1_nw_reg   <= nw;
            c1_ovf_reg  <= b2_ovf_reg | ovf_v | ovf_w;
            c2_axis_reg <= c1_axis_reg;
            c2_nv_reg   <= c1_nv_reg;
            c2_nw_reg   <= c1_nw_reg;
            c2_ovf_reg  <= c1_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= vld_reg[DIV_LAT-1];
            b1_vld_reg <= a_vld_reg;
            b2_vld_reg <= b1_vld_reg;
            c1_vld_reg <= b2_vld_reg;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    // Output register with one skid entry
    logic last_valid;
    rsp_t last_data;
    logic out_free;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg, skid_data_reg;

    assign last_valid = c2_vld_reg & en;
    assign out_free   = ~rsp_valid_reg | rsp_ready;

    always_comb
    begin
        last_data.axis_out             = c2_axis_reg;
        last_data.new_velocity         = c2_nv_reg;
        last_data.new_angular_velocity = c2_nw_reg;
        last_data.new_position         = np;
        last_data.overflow             = c2_ovf_reg | ovf_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg  <= skid_valid_reg | last_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (last_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            rsp_data_reg <= skid_valid_reg ? skid_data_reg : last_data;
        end
        else if (last_valid)
        begin
            skid_data_reg <= last_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTH
    // The skid entry only fills behind a held response
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid entry occupied with empty output register");

    // While the skid entry is full, the pipeline tail must hold its item
    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> (c2_vld_reg == $past(c2_vld_reg)))
        else $error("pipeline tail moved during stall");

    // A full skid entry drains into the output register when the response is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rsp_ready) |=> (rsp_valid_reg && !skid_valid_reg))
        else $error("skid entry lost or not drained");
`endif

endmodule

// ===== tb/tb_particle_euler_integrator.sv =====
// Self-checking testbench for particle_euler_integrator: a directed table, then random
// phases with varied gravity and time step, checked against an in-bench integrator model.
// Depends on pei_pkg and the RTL of the block; needs nothing else.
module tb_particle_euler_integrator;
    import pei_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC_BITS       = 16;
    localparam logic [1:0]  AXIS_NONE       = 2'd3;
    localparam longint      WORD_MAX        = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint      WORD_MIN        = -WORD_MAX - 1;
    localparam int          N_PHASES        = 8;
    localparam int          ITEMS_PER_PHASE = 142;
    localparam int          HOLD_PHASE      = 3;
    localparam int          PAUSE_PHASE     = 5;
    localparam int          LONG_HOLD       = 400;
    localparam int          TAIL_CYCLES     = WORD_BITS + FRAC_BITS + 16;
    localparam int          STALL_LIMIT     = 3000;
    localparam int          PRINT_LIMIT     = 100;

    typedef struct {
        bit          is_cfg;
        cfg_reg_t    reg_idx;
        logic [31:0] reg_val;
        req_t        item;
        bit          typed;
        rsp_t        want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req_data;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [WORD_BITS-1:0] cfg_data;

    // Register copies, reset values
    logic signed [31:0] grav_x   = '0;
    logic signed [31:0] grav_y   = '0;
    logic signed [31:0] grav_z   = '0;
    logic [30:0]        step_q16 = '0;

    rsp_t     due_updates[$];
    dir_row_t script[$];
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    bit       req_gap_on   = 1'b1;
    bit       rsp_stall_on = 1'b1;
    bit       hold_long    = 1'b0;

    particle_euler_integrator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint fit_word(input longint v, inout bit ovf);
        if (v > WORD_MAX)
        begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // One semi-implicit Euler step of one axis under the current register copies
    function automatic rsp_t integrate_axis(input req_t r);
        rsp_t   o;
        bit     ovf;
        longint g, q_lin, q_ang, acc, nv, np, nw, dt;
        ovf = 1'b0;
        dt  = longint'(step_q16);
        case (r.axis)
            AXIS_X:  g = longint'(grav_x);
            AXIS_Y:  g = longint'(grav_y);
            AXIS_Z:  g = longint'(grav_z);
            default: g = 0;
        endcase
        if (r.mass == '0)
        begin
            q_lin = 0;
            ovf   = 1'b1;
        end
        else
            q_lin = fit_word((longint'($signed(r.force_req)) <<< FRAC_BITS)
                             / longint'(r.mass), ovf);
        if (r.moment_of_inertia == '0)
        begin
            q_ang = 0;
            ovf   = 1'b1;
        end
        else
            q_ang = fit_word((longint'($signed(r.torque)) <<< FRAC_BITS)
                             / longint'(r.moment_of_inertia), ovf);
        acc = fit_word(g + q_lin, ovf);
        // position advances with the updated velocity
        nv  = fit_word(longint'($signed(r.velocity)) + ((dt * acc) >>> FRAC_BITS), ovf);
        np  = fit_word(longint'($signed(r.position)) + ((dt * nv) >>> FRAC_BITS), ovf);
        nw  = fit_word(longint'($signed(r.angular_velocity)) + ((dt * q_ang) >>> FRAC_BITS),
                       ovf);
        o.axis_out             = r.axis;
        o.new_velocity         = nv[31:0];
        o.new_angular_velocity = nw[31:0];
        o.new_position         = np[31:0];
        o.overflow             = ovf;
        return o;
    endfunction

    function automatic req_t mk_req(input logic [1:0] axis, input logic [30:0] mass,
                                    input logic [30:0] moi, input logic [31:0] f,
                                    input logic [31:0] t, input logic [31:0] v,
                                    input logic [31:0] w, input logic [31:0] p);
        req_t r;
        r.axis              = axis;
        r.mass              = mass;
        r.moment_of_inertia = moi;
        r.force_req         = f;
        r.torque            = t;
        r.velocity          = v;
        r.angular_velocity  = w;
        r.position          = p;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input logic [1:0] axis, input logic [31:0] nv,
                                    input logic [31:0] nw, input logic [31:0] np,
                                    input logic ovf);
        rsp_t o;
        o.axis_out             = axis;
        o.new_velocity         = nv;
        o.new_angular_velocity = nw;
        o.new_position         = np;
        o.overflow             = ovf;
        return o;
    endfunction

    function automatic dir_row_t req_row(input req_t item, input bit typed, input rsp_t want);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = REG_GRAVITY_X;
        row.reg_val = '0;
        row.item    = item;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] val);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(0, 32'h3f_ffff) - 32'h20_0000;
        endcase
    endfunction

    function automatic logic [30:0] pick_divisor();
        case ($urandom_range(0, 9))
            0:       return 31'h0;
            1:       return 31'h1;
            2:       return 31'h7fff_ffff;
            3, 4:    return 31'($urandom);
            default: return 31'($urandom_range(32'h100, 32'h10_0000));
        endcase
    endfunction

    function automatic logic [31:0] pick_gravity();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1, 2:    return $urandom;
            default: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
        endcase
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Leave cfg_valid high; the caller drops it once its writes are done
    task automatic set_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_GRAVITY_X: grav_x   = val;
            REG_GRAVITY_Y: grav_y   = val;
            REG_GRAVITY_Z: grav_z   = val;
            REG_TIME_STEP: step_q16 = val[30:0];
            default:       ;
        endcase
    endtask

    task automatic offer(input req_t r, input bit typed, input rsp_t want);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        due_updates.push_back(typed ? want : integrate_axis(r));
    endtask

    task automatic maybe_gap();
        if (req_gap_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Drop the request and hold until every outstanding response is back
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (due_updates.size() != 0)
            @(posedge clk);
    endtask

    // Response side: random stalls plus one long hold-off on demand
    initial
    begin
        int stall;
        stall     = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                stall     = LONG_HOLD;
            end
            else if (stall == 0 && rsp_stall_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 14);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: unexpected response: expected none, got %h",
                             $time, rsp_data);
            end
            else
            begin
                want = due_updates.pop_front();
                check_field("axis_out", 32'(want.axis_out), 32'(rsp_data.axis_out));
                check_field("new_velocity", want.new_velocity, rsp_data.new_velocity);
                check_field("new_angular_velocity", want.new_angular_velocity,
                            rsp_data.new_angular_velocity);
                check_field("new_position", want.new_position, rsp_data.new_position);
                check_field("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_particle_euler_integrator NOT OK");
            $finish;
        end
    end

    initial
    begin
        int          p;
        int          n;
        logic [31:0] step_word;
        logic [1:0]  axis;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRAVITY_X;
        cfg_data  = '0;

        // Registers at reset: no gravity, zero step, so only the flags can move
        script.push_back(req_row(mk_req(AXIS_X, 31'h1_0000, 31'h1_0000, 32'h0005_0000,
                                        32'hfffd_0000, 32'h0001_0000, 32'h0002_0000,
                                        32'hffff_8000), 1'b1,
                                 mk_rsp(AXIS_X, 32'h0001_0000, 32'h0002_0000,
                                        32'hffff_8000, 1'b0)));
        // zero mass
        script.push_back(req_row(mk_req(AXIS_Y, 31'h0, 31'h1_0000, 32'h1234_5678, 32'h0,
                                        32'h1111_1111, 32'h2222_2222, 32'h3333_3333), 1'b1,
                                 mk_rsp(AXIS_Y, 32'h1111_1111, 32'h2222_2222,
                                        32'h3333_3333, 1'b1)));
        // zero moment of inertia
        script.push_back(req_row(mk_req(AXIS_Z, 31'h1_0000, 31'h0, 32'h0, 32'h4444_0000,
                                        32'hdead_beef, 32'h8000_0000, 32'h7fff_ffff), 1'b1,
                                 mk_rsp(AXIS_Z, 32'hdead_beef, 32'h8000_0000,
                                        32'h7fff_ffff, 1'b1)));
        // axis three echoes and takes no gravity
        script.push_back(req_row(mk_req(AXIS_NONE, 31'h1_0000, 31'h1_0000, 32'h0, 32'h0,
                                        32'h7fff_ffff, 32'h8000_0000, 32'h0), 1'b1,
                                 mk_rsp(AXIS_NONE, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h0, 1'b0)));
        // force quotient saturates high
        script.push_back(req_row(mk_req(AXIS_X, 31'h1, 31'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h7fff_ffff), 1'b1,
                                 mk_rsp(AXIS_X, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h7fff_ffff, 1'b1)));
        script.push_back(req_row(mk_req(AXIS_Y, 31'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h0, 32'h0, 32'h0), 1'b1,
                                 mk_rsp(AXIS_Y, 32'h0, 32'h0, 32'h0, 1'b0)));
        // torque quotient saturates low
        script.push_back(req_row(mk_req(AXIS_Z, 31'h1_0000, 31'h1, 32'h0, 32'h8000_0000,
                                        32'h5, 32'h6, 32'h7), 1'b1,
                                 mk_rsp(AXIS_Z, 32'h5, 32'h6, 32'h7, 1'b1)));

        // Extreme gravity and the largest step
        script.push_back(cfg_row(REG_GRAVITY_X, 32'h7fff_ffff));
        script.push_back(cfg_row(REG_GRAVITY_Y, 32'h8000_0000));
        script.push_back(cfg_row(REG_GRAVITY_Z, 32'hfff6_3d71));
        script.push_back(cfg_row(REG_TIME_STEP, 32'h7fff_ffff));
        script.push_back(req_row(mk_req(AXIS_X, 31'h1_0000, 31'h1_0000, 32'h1_0000,
                                        32'h1_0000, 32'h1_0000, 32'hffff_0000,
                                        32'h0010_0000), 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_Y, 31'h1_0000, 31'h8000, 32'hffff_0000,
                                        32'hfff0_0000, 32'h0, 32'h0, 32'h0), 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_Z, 31'h7fff_ffff, 31'h7fff_ffff, 32'h0, 32'h0,
                                        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000),
                                 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_NONE, 31'h1, 31'h1, 32'h1, 32'hffff_ffff,
                                        32'h0, 32'h0, 32'h0), 1'b0, '0));

        // Smallest step, top data bit set to check it is dropped; floor on negatives
        script.push_back(cfg_row(REG_TIME_STEP, 32'h8000_0001));
        script.push_back(cfg_row(REG_GRAVITY_X, 32'h0000_8000));
        script.push_back(req_row(mk_req(AXIS_Z, 31'h1_0000, 31'h1_0000, 32'h0, 32'hffff_ffff,
                                        32'h0, 32'h0, 32'h0), 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_X, 31'h1_0000, 31'h3_0000, 32'h1_0000,
                                        32'h1_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff),
                                 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_Y, 31'h1_0000, 31'h1_0000, 32'h0, 32'h0,
                                        32'h8000_0000, 32'h0, 32'h0), 1'b0, '0));

        // Unit step
        script.push_back(cfg_row(REG_TIME_STEP, 32'h0001_0000));
        script.push_back(cfg_row(REG_GRAVITY_Z, 32'h0));
        script.push_back(req_row(mk_req(AXIS_Z, 31'h2_0000, 31'h1_0000, 32'hffff_0000,
                                        32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                                        32'h7fff_0000), 1'b0, '0));
        script.push_back(req_row(mk_req(AXIS_X, 31'h0, 31'h0, 32'h0001_0000, 32'h0001_0000,
                                        32'h0002_0000, 32'h0003_0000, 32'h0004_0000),
                                 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                wait_idle();
                set_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                cfg_valid <= 1'b0;
                maybe_gap();
                offer(script[i].item, script[i].typed, script[i].want);
            end
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            req_gap_on   = (p != HOLD_PHASE) && (p != 4) && (p != N_PHASES - 1);
            rsp_stall_on = (p != 6) && (p != N_PHASES - 1);

            step_word = $urandom_range(1, 32'h4000);
            if ($urandom_range(0, 3) == 0)
                step_word = $urandom;
            if (p == 1)
                step_word = 32'h7fff_ffff;
            else if (p == 2)
                step_word = '0;
            step_word[31] = 1'($urandom_range(0, 1));

            set_reg(REG_GRAVITY_X, pick_gravity());
            set_reg(REG_GRAVITY_Y, pick_gravity());
            set_reg(REG_GRAVITY_Z, pick_gravity());
            set_reg(REG_TIME_STEP, step_word);
            cfg_valid <= 1'b0;

            // Back up the pipeline: responses held off while requests keep coming
            if (p == HOLD_PHASE)
                hold_long = 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                maybe_gap();
                axis = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
                offer(mk_req(axis, pick_divisor(), pick_divisor(), pick_word(), pick_word(),
                             pick_word(), pick_word(), pick_word()), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_particle_euler_integrator OK");
        else
            $display("tb_particle_euler_integrator NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pei_pkg.sv
sv/pei_div.sv
sv/pei_adv.sv
sv/particle_euler_integrator.sv
tb/tb_particle_euler_integrator.sv
